// ===== hdl/pea_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pea_pkg
// shared types and constants of the power and energy accumulator
// ----------------------------------------------------------------------------
package pea_pkg;

    localparam int TIME_W    = 32;
    localparam int VOLT_W    = 15;
    localparam int CUR_W     = 16;
    localparam int POW_W     = 19;
    localparam int SPER_W    = 16;
    localparam int ENERGY_W  = 63;
    localparam int CHARGE_W  = 64;
    localparam int EPROD_W   = POW_W + TIME_W;
    localparam int QPROD_W   = CUR_W + TIME_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int DIV_STEPS = 64;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIVE_PERIOD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUMMARY_PERIOD = 2'd2;

    localparam logic [SPER_W-1:0] SAMPLE_PERIOD_RST  = 16'd100;
    localparam logic [TIME_W-1:0] LIVE_PERIOD_RST    = 32'd1000;
    localparam logic [TIME_W-1:0] SUMMARY_PERIOD_RST = 32'd60000;

    localparam logic [VOLT_W-1:0]   VOLT_MAX_VAL  = '1;
    localparam logic [CUR_W-1:0]    CUR_MAX_VAL   = 16'h7fff;
    localparam logic [CUR_W-1:0]    CUR_MIN_VAL   = 16'h8000;
    localparam logic [POW_W-1:0]    POW_MAX_VAL   = '1;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX    = '1;
    localparam logic [CHARGE_W-1:0] CHARGE_MAX    = 64'h7fff_ffff_ffff_ffff;
    localparam logic [CHARGE_W-1:0] CHARGE_MIN    = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [TIME_W-1:0]       timestamp_ms;
        logic [VOLT_W-1:0]       bus_voltage_mv;
        logic signed [CUR_W-1:0] current_tenth_ma;
        logic [POW_W-1:0]        power_tenth_mw;
    } t_in_beat;

    typedef struct packed {
        logic                       sample_taken;
        logic                       live_due;
        logic                       summary_due;
        logic [ENERGY_W-1:0]        energy_sum;
        logic signed [CHARGE_W-1:0] charge_sum;
        logic [VOLT_W-1:0]          voltage_min;
        logic [VOLT_W-1:0]          voltage_max;
        logic signed [CUR_W-1:0]    current_min;
        logic signed [CUR_W-1:0]    current_max;
        logic [POW_W-1:0]           power_peak;
        logic [POW_W-1:0]           average_power;
        logic signed [CUR_W-1:0]    average_current;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_DIV_LOAD,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic compute;
        logic accumulate;
        logic div_load;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_need;
    } t_status;

endpackage

// ===== hdl/power_energy_accumulator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_energy_accumulator_unit
// energy and charge accumulator with running extremes and periodic averages
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// in        sink       i_in_valid/o_in_stall  t_in_beat, one reading per beat
// out       source     o_out_valid/i_out_stall t_out_beat, one result per beat
// cfg       sink       i_cfg_valid/o_cfg_ready index 0..2, 32-bit data
//
// one beat at a time: accept, multiply, accumulate, then on a summary beat with
// nonzero elapsed time a divider load and the 64-step serial divider, then the
// result register load; a new beat is taken once the result is loaded
// synchronous active-low reset, no clearing pass
// a stalled result holds in the output register while the next beat runs
// ----------------------------------------------------------------------------
module power_energy_accumulator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pea_pkg::t_in_beat             i_in_beat,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pea_pkg::t_out_beat            o_out_beat,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pea_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pea_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    pea_pkg::t_cmd    cmd;
    pea_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    pea_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pea_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_beat   (i_in_beat),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_beat  (o_out_beat)
    );

endmodule

// ===== hdl/pea_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pea_ctrl
// sequencer for capture, multiply, accumulate, divide and output load
// ----------------------------------------------------------------------------
module pea_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  pea_pkg::t_status i_status,
    output pea_pkg::t_cmd    o_cmd
);

    pea_pkg::t_state           r_state, n_state;
    logic [pea_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      r_out_valid, n_out_valid;
    logic                      out_free;
    logic                      cnt_last;

    assign out_free = !r_out_valid || !i_out_stall;
    assign cnt_last = (r_cnt == pea_pkg::CNT_W'(pea_pkg::DIV_STEPS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            pea_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = pea_pkg::S_MUL;
                end
            end
            pea_pkg::S_MUL: begin
                n_state = pea_pkg::S_ACC;
            end
            pea_pkg::S_ACC: begin
                n_state = i_status.div_need ? pea_pkg::S_DIV_LOAD : pea_pkg::S_DONE;
            end
            pea_pkg::S_DIV_LOAD: begin
                n_state = pea_pkg::S_DIV;
            end
            pea_pkg::S_DIV: begin
                if (cnt_last) begin
                    n_state = pea_pkg::S_DONE;
                end
            end
            pea_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = pea_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pea_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            pea_pkg::S_IDLE: begin
                o_cmd.capture = i_in_valid;
            end
            pea_pkg::S_MUL: begin
                o_cmd.compute = 1'b1;
            end
            pea_pkg::S_ACC: begin
                o_cmd.accumulate = 1'b1;
            end
            pea_pkg::S_DIV_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = '0;
            end
            pea_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
            end
            pea_pkg::S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pea_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != pea_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/pea_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pea_dp
// config registers, sample gate, products, saturating sums, extremes and
// the bit-serial divider for the averages
// ----------------------------------------------------------------------------
module pea_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pea_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pea_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  pea_pkg::t_in_beat                 i_in_beat,
    input  pea_pkg::t_cmd                     i_cmd,
    output pea_pkg::t_status                  o_status,
    output pea_pkg::t_out_beat                o_out_beat
);

    // configuration
    logic [pea_pkg::SPER_W-1:0] r_sample_period;
    logic [pea_pkg::TIME_W-1:0] r_live_period;
    logic [pea_pkg::TIME_W-1:0] r_summary_period;

    // accumulator state
    logic                               r_started;
    logic [pea_pkg::TIME_W-1:0]         r_start_time;
    logic [pea_pkg::TIME_W-1:0]         r_prev_time;
    logic [pea_pkg::TIME_W-1:0]         r_next_live;
    logic [pea_pkg::TIME_W-1:0]         r_next_summary;
    logic [pea_pkg::ENERGY_W-1:0]       r_energy;
    logic signed [pea_pkg::CHARGE_W-1:0] r_charge;
    logic [pea_pkg::VOLT_W-1:0]         r_low_volt;
    logic [pea_pkg::VOLT_W-1:0]         r_high_volt;
    logic signed [pea_pkg::CUR_W-1:0]   r_low_cur;
    logic signed [pea_pkg::CUR_W-1:0]   r_high_cur;
    logic [pea_pkg::POW_W-1:0]          r_peak_pow;

    // captured beat and multiply stage
    pea_pkg::t_in_beat                  r_in;
    logic                               r_first;
    logic                               r_taken;
    logic                               r_live_hit;
    logic                               r_summ_hit;
    logic                               r_div_need;
    logic [pea_pkg::TIME_W-1:0]         r_elapsed;
    logic [pea_pkg::EPROD_W-1:0]        r_eprod;
    logic signed [pea_pkg::QPROD_W-1:0] r_qprod;

    // divider
    logic [pea_pkg::CHARGE_W-1:0] r_num_e;
    logic [pea_pkg::CHARGE_W-1:0] r_num_q;
    logic [pea_pkg::TIME_W-1:0]   r_rem_e;
    logic [pea_pkg::TIME_W-1:0]   r_rem_q;
    logic                         r_q_neg;

    pea_pkg::t_out_beat r_out;

    logic [pea_pkg::TIME_W-1:0]         dt;
    logic [pea_pkg::TIME_W-1:0]         live_diff;
    logic [pea_pkg::TIME_W-1:0]         summ_diff;
    logic [pea_pkg::TIME_W-1:0]         elapsed;
    logic                               gate;
    logic [pea_pkg::EPROD_W-1:0]        eprod_w;
    logic signed [pea_pkg::QPROD_W-1:0] qprod_w;
    logic [pea_pkg::ENERGY_W:0]         esum_w;
    logic [pea_pkg::ENERGY_W-1:0]       n_energy;
    logic signed [pea_pkg::CHARGE_W:0]  csum_w;
    logic signed [pea_pkg::CHARGE_W-1:0] n_charge;
    logic [pea_pkg::TIME_W:0]           rsh_e;
    logic [pea_pkg::TIME_W:0]           rsh_q;
    logic [pea_pkg::TIME_W:0]           rsub_e;
    logic [pea_pkg::TIME_W:0]           rsub_q;
    logic                               ge_e;
    logic                               ge_q;
    logic [pea_pkg::POW_W-1:0]          avg_p;
    logic [pea_pkg::CUR_W-1:0]          avg_i;
    logic [pea_pkg::CUR_W-1:0]          neg_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period  <= pea_pkg::SAMPLE_PERIOD_RST;
            r_live_period    <= pea_pkg::LIVE_PERIOD_RST;
            r_summary_period <= pea_pkg::SUMMARY_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pea_pkg::CFG_SAMPLE_PERIOD: begin
                    r_sample_period <= i_cfg_data[pea_pkg::SPER_W-1:0];
                end
                pea_pkg::CFG_LIVE_PERIOD: begin
                    r_live_period <= i_cfg_data;
                end
                pea_pkg::CFG_SUMMARY_PERIOD: begin
                    r_summary_period <= i_cfg_data;
                end
                default: begin
                    r_sample_period <= r_sample_period;
                end
            endcase
        end
    end

    // sample gate and products
    assign dt        = r_in.timestamp_ms - r_prev_time;
    assign live_diff = r_in.timestamp_ms - r_next_live;
    assign summ_diff = r_in.timestamp_ms - r_next_summary;
    assign elapsed   = r_in.timestamp_ms - r_start_time;
    assign gate      = r_started && !dt[pea_pkg::TIME_W-1] &&
                       (dt >= pea_pkg::TIME_W'(r_sample_period));
    assign eprod_w   = pea_pkg::EPROD_W'(r_in.power_tenth_mw) * pea_pkg::EPROD_W'(dt);
    assign qprod_w   = pea_pkg::QPROD_W'(r_in.current_tenth_ma) * $signed({1'b0, dt});

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_beat;
        end
        if (i_cmd.compute) begin
            r_first    <= !r_started;
            r_taken    <= gate;
            r_live_hit <= gate && !live_diff[pea_pkg::TIME_W-1];
            r_summ_hit <= gate && !summ_diff[pea_pkg::TIME_W-1];
            r_div_need <= gate && !summ_diff[pea_pkg::TIME_W-1] && (elapsed != '0);
            r_elapsed  <= elapsed;
            r_eprod    <= eprod_w;
            r_qprod    <= qprod_w;
        end
    end

    // saturating sums
    assign esum_w   = {1'b0, r_energy} + (pea_pkg::ENERGY_W + 1)'(r_eprod);
    assign n_energy = esum_w[pea_pkg::ENERGY_W] ? pea_pkg::ENERGY_MAX
                                                : esum_w[pea_pkg::ENERGY_W-1:0];
    assign csum_w   = (pea_pkg::CHARGE_W + 1)'(r_charge) + (pea_pkg::CHARGE_W + 1)'(r_qprod);

    always_comb begin
        n_charge = csum_w[pea_pkg::CHARGE_W-1:0];
        if (csum_w[pea_pkg::CHARGE_W] != csum_w[pea_pkg::CHARGE_W-1]) begin
            n_charge = r_qprod[pea_pkg::QPROD_W-1] ? pea_pkg::CHARGE_MIN : pea_pkg::CHARGE_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started      <= 1'b0;
            r_start_time   <= '0;
            r_prev_time    <= '0;
            r_next_live    <= '0;
            r_next_summary <= '0;
            r_energy       <= '0;
            r_charge       <= '0;
            r_low_volt     <= pea_pkg::VOLT_MAX_VAL;
            r_high_volt    <= '0;
            r_low_cur      <= pea_pkg::CUR_MAX_VAL;
            r_high_cur     <= pea_pkg::CUR_MIN_VAL;
            r_peak_pow     <= '0;
        end else if (i_cmd.accumulate) begin
            if (r_first) begin
                r_started      <= 1'b1;
                r_start_time   <= r_in.timestamp_ms;
                r_prev_time    <= r_in.timestamp_ms;
                r_next_live    <= r_in.timestamp_ms + r_live_period;
                r_next_summary <= r_in.timestamp_ms + r_summary_period;
            end else if (r_taken) begin
                r_prev_time <= r_in.timestamp_ms;
                r_energy    <= n_energy;
                r_charge    <= n_charge;
                if (r_in.bus_voltage_mv < r_low_volt) begin
                    r_low_volt <= r_in.bus_voltage_mv;
                end
                if (r_in.bus_voltage_mv > r_high_volt) begin
                    r_high_volt <= r_in.bus_voltage_mv;
                end
                if ($signed(r_in.current_tenth_ma) < r_low_cur) begin
                    r_low_cur <= r_in.current_tenth_ma;
                end
                if ($signed(r_in.current_tenth_ma) > r_high_cur) begin
                    r_high_cur <= r_in.current_tenth_ma;
                end
                if (r_in.power_tenth_mw > r_peak_pow) begin
                    r_peak_pow <= r_in.power_tenth_mw;
                end
                if (r_live_hit) begin
                    r_next_live <= r_in.timestamp_ms + r_live_period;
                end
                if (r_summ_hit) begin
                    r_next_summary <= r_in.timestamp_ms + r_summary_period;
                end
            end
        end
    end

    // restoring divider, one quotient bit per cycle on both sums
    assign rsh_e  = {r_rem_e, r_num_e[pea_pkg::CHARGE_W-1]};
    assign rsh_q  = {r_rem_q, r_num_q[pea_pkg::CHARGE_W-1]};
    assign rsub_e = rsh_e - {1'b0, r_elapsed};
    assign rsub_q = rsh_q - {1'b0, r_elapsed};
    assign ge_e   = (rsh_e >= {1'b0, r_elapsed});
    assign ge_q   = (rsh_q >= {1'b0, r_elapsed});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_num_e <= {1'b0, r_energy};
            r_num_q <= r_charge[pea_pkg::CHARGE_W-1] ? -r_charge : r_charge;
            r_q_neg <= r_charge[pea_pkg::CHARGE_W-1];
            r_rem_e <= '0;
            r_rem_q <= '0;
        end else if (i_cmd.div_step) begin
            r_num_e <= {r_num_e[pea_pkg::CHARGE_W-2:0], ge_e};
            r_num_q <= {r_num_q[pea_pkg::CHARGE_W-2:0], ge_q};
            r_rem_e <= ge_e ? rsub_e[pea_pkg::TIME_W-1:0] : rsh_e[pea_pkg::TIME_W-1:0];
            r_rem_q <= ge_q ? rsub_q[pea_pkg::TIME_W-1:0] : rsh_q[pea_pkg::TIME_W-1:0];
        end
    end

    // average clamp
    assign neg_q = -r_num_q[pea_pkg::CUR_W-1:0];

    always_comb begin
        avg_p = '0;
        avg_i = '0;
        if (r_div_need) begin
            avg_p = (r_num_e > pea_pkg::CHARGE_W'(pea_pkg::POW_MAX_VAL))
                    ? pea_pkg::POW_MAX_VAL : r_num_e[pea_pkg::POW_W-1:0];
            if (r_q_neg) begin
                avg_i = (r_num_q > pea_pkg::CHARGE_W'(pea_pkg::CUR_MIN_VAL))
                        ? pea_pkg::CUR_MIN_VAL : neg_q;
            end else begin
                avg_i = (r_num_q > pea_pkg::CHARGE_W'(pea_pkg::CUR_MAX_VAL))
                        ? pea_pkg::CUR_MAX_VAL : r_num_q[pea_pkg::CUR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.sample_taken    <= r_taken && !r_first;
            r_out.live_due        <= r_live_hit && !r_first;
            r_out.summary_due     <= r_summ_hit && !r_first;
            r_out.energy_sum      <= r_energy;
            r_out.charge_sum      <= r_charge;
            r_out.voltage_min     <= r_low_volt;
            r_out.voltage_max     <= r_high_volt;
            r_out.current_min     <= r_low_cur;
            r_out.current_max     <= r_high_cur;
            r_out.power_peak      <= r_peak_pow;
            r_out.average_power   <= (r_first ? '0 : avg_p);
            r_out.average_current <= (r_first ? '0 : avg_i);
        end
    end

    assign o_status.div_need = r_div_need;
    assign o_out_beat        = r_out;

endmodule

// ===== hdl/pea_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pea_checker
// port-level checks of the power and energy accumulator
// ----------------------------------------------------------------------------
module pea_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input pea_pkg::t_out_beat o_out_beat
);

    // held result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("result beat changed while stalled");

    a_flags_need_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_beat.sample_taken |->
            !o_out_beat.live_due && !o_out_beat.summary_due)
        else $error("deadline flag without sample");

    a_avg_only_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_beat.summary_due |->
            o_out_beat.average_power == '0 && o_out_beat.average_current == '0)
        else $error("average outside summary beat");

    a_extremes_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.sample_taken |->
            o_out_beat.voltage_min <= o_out_beat.voltage_max &&
            o_out_beat.current_min <= o_out_beat.current_max)
        else $error("min above max after sample");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled while beat in flight");

endmodule

bind power_energy_accumulator_unit pea_checker u_pea_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

// ===== tb/tb_power_energy_accumulator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_power_energy_accumulator_unit
// self-checking bench for the energy and charge accumulator
// readings go in with random gaps while the result side stalls at random;
// a bit-exact model of the gate, the extremes, the saturating sums, the
// deadlines and the averages predicts every result beat, and each beat is
// compared field by field across several register settings, zero and
// all-ones periods among them
// ----------------------------------------------------------------------------
module tb_power_energy_accumulator_unit;
    import pea_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned RUN_LIMIT     = 1_000_000;
    localparam int          SETTLE        = 100;
    localparam int          PHASE_SAMPLES = 160;
    localparam int          MAX_PRINTED   = 100;
    localparam bit [31:0]   HALF_TURN     = 32'h8000_0000;
    localparam bit [31:0]   QUARTER_TURN  = 32'h4000_0000;
    localparam bit [63:0]   ENERGY_TOP    = 64'(ENERGY_MAX);
    localparam longint      CHARGE_TOP    = longint'(CHARGE_MAX);
    localparam longint      CHARGE_BOTTOM = longint'(CHARGE_MIN);
    localparam longint      AVG_CUR_TOP   = longint'(signed'(CUR_MAX_VAL));
    localparam longint      AVG_CUR_BOTTOM = longint'(signed'(CUR_MIN_VAL));

    class accumulator_tracker;
        bit [SPER_W-1:0]         sample_period;
        bit [TIME_W-1:0]         live_period;
        bit [TIME_W-1:0]         summary_period;
        bit                      started;
        bit [TIME_W-1:0]         start_time;
        bit [TIME_W-1:0]         prev_time;
        bit [TIME_W-1:0]         next_live;
        bit [TIME_W-1:0]         next_summary;
        bit [63:0]               energy;
        longint                  charge;
        bit [VOLT_W-1:0]         volt_lo;
        bit [VOLT_W-1:0]         volt_hi;
        logic signed [CUR_W-1:0] cur_lo;
        logic signed [CUR_W-1:0] cur_hi;
        bit [POW_W-1:0]          pow_peak;
        t_out_beat               pending_results[$];
        int                      errors;
        int                      beats;
        int                      checked;
        int                      samples;
        int                      lives;
        int                      summaries;

        function new();
            sample_period  = SAMPLE_PERIOD_RST;
            live_period    = LIVE_PERIOD_RST;
            summary_period = SUMMARY_PERIOD_RST;
            volt_lo        = VOLT_MAX_VAL;
            volt_hi        = '0;
            cur_lo         = CUR_MAX_VAL;
            cur_hi         = CUR_MIN_VAL;
            pow_peak       = '0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_SAMPLE_PERIOD:  sample_period  = data[SPER_W-1:0];
                CFG_LIVE_PERIOD:    live_period    = data;
                CFG_SUMMARY_PERIOD: summary_period = data;
                default: ;
            endcase
        endfunction

        function void note_reading(t_in_beat rd);
            bit [TIME_W-1:0]         now;
            bit [TIME_W-1:0]         gap;
            bit [TIME_W-1:0]         lag;
            bit [TIME_W-1:0]         elapsed;
            bit [63:0]               eprod;
            bit [63:0]               avg_p;
            longint                  qprod;
            longint                  avg_i;
            logic signed [CUR_W-1:0] cur;
            t_out_beat               res;
            now   = rd.timestamp_ms;
            cur   = rd.current_tenth_ma;
            res   = '0;
            avg_p = '0;
            avg_i = 0;
            beats++;
            if (!started) begin
                started      = 1'b1;
                start_time   = now;
                prev_time    = now;
                next_live    = now + live_period;
                next_summary = now + summary_period;
            end else begin
                gap = now - prev_time;
                if (!gap[31] && gap >= 32'(sample_period)) begin
                    eprod = 64'(rd.power_tenth_mw) * 64'(gap);
                    qprod = longint'(cur) * longint'(64'(gap));
                    res.sample_taken = 1'b1;
                    samples++;
                    prev_time = now;
                    if (rd.bus_voltage_mv < volt_lo) volt_lo = rd.bus_voltage_mv;
                    if (rd.bus_voltage_mv > volt_hi) volt_hi = rd.bus_voltage_mv;
                    if (cur < cur_lo) cur_lo = cur;
                    if (cur > cur_hi) cur_hi = cur;
                    if (rd.power_tenth_mw > pow_peak) pow_peak = rd.power_tenth_mw;

                    if (energy > ENERGY_TOP - eprod) energy = ENERGY_TOP;
                    else energy = energy + eprod;

                    if (qprod > 0 && charge > CHARGE_TOP - qprod) charge = CHARGE_TOP;
                    else if (qprod < 0 && charge < CHARGE_BOTTOM - qprod) charge = CHARGE_BOTTOM;
                    else charge = charge + qprod;

                    lag = now - next_live;
                    if (!lag[31]) begin
                        res.live_due = 1'b1;
                        lives++;
                        next_live = now + live_period;
                    end
                    lag = now - next_summary;
                    if (!lag[31]) begin
                        res.summary_due = 1'b1;
                        summaries++;
                        elapsed = now - start_time;
                        if (elapsed != 0) begin
                            avg_p = energy / 64'(elapsed);
                            if (avg_p > 64'(POW_MAX_VAL)) avg_p = 64'(POW_MAX_VAL);
                            avg_i = charge / longint'(64'(elapsed));
                            if (avg_i > AVG_CUR_TOP) avg_i = AVG_CUR_TOP;
                            if (avg_i < AVG_CUR_BOTTOM) avg_i = AVG_CUR_BOTTOM;
                        end
                        next_summary = now + summary_period;
                    end
                end
            end
            res.energy_sum      = energy[ENERGY_W-1:0];
            res.charge_sum      = charge;
            res.voltage_min     = volt_lo;
            res.voltage_max     = volt_hi;
            res.current_min     = cur_lo;
            res.current_max     = cur_hi;
            res.power_peak      = pow_peak;
            res.average_power   = avg_p[POW_W-1:0];
            res.average_current = avg_i[CUR_W-1:0];
            pending_results.push_back(res);
        endfunction

        task report(string field, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("error at result %0d: %s got %h want %h", checked, field, got, want);
        endtask

        task check_result(t_out_beat got);
            t_out_beat want;
            checked++;
            if (pending_results.size() == 0) begin
                report("result with none pending", '0, '0);
                return;
            end
            want = pending_results.pop_front();
            if (got.sample_taken !== want.sample_taken)
                report("sample_taken", got.sample_taken, want.sample_taken);
            if (got.live_due !== want.live_due)
                report("live_due", got.live_due, want.live_due);
            if (got.summary_due !== want.summary_due)
                report("summary_due", got.summary_due, want.summary_due);
            if (got.energy_sum !== want.energy_sum)
                report("energy_sum", got.energy_sum, want.energy_sum);
            if (got.charge_sum !== want.charge_sum)
                report("charge_sum", got.charge_sum, want.charge_sum);
            if (got.voltage_min !== want.voltage_min)
                report("voltage_min", got.voltage_min, want.voltage_min);
            if (got.voltage_max !== want.voltage_max)
                report("voltage_max", got.voltage_max, want.voltage_max);
            if (got.current_min !== want.current_min)
                report("current_min", got.current_min, want.current_min);
            if (got.current_max !== want.current_max)
                report("current_max", got.current_max, want.current_max);
            if (got.power_peak !== want.power_peak)
                report("power_peak", got.power_peak, want.power_peak);
            if (got.average_power !== want.average_power)
                report("average_power", got.average_power, want.average_power);
            if (got.average_current !== want.average_current)
                report("average_current", got.average_current, want.average_current);
        endtask
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_beat              in_beat   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_beat             out_beat;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data  = '0;

    bit                    quiet     = 1'b0;
    int                    long_hold = 0;
    accumulator_tracker    tracker   = new();

    power_energy_accumulator_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still pending", cycles, tracker.pending());
        $display("power_energy_accumulator_unit: mismatch");
        $finish;
    end

    // result side: random stall bursts plus the long hold-off on request
    initial begin : result_sink
        int burst;
        int hold;
        burst = 0;
        hold  = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) tracker.check_result(out_beat);
            if (long_hold > 0) begin
                hold      = long_hold;
                long_hold = 0;
            end
            if (burst == 0 && hold == 0 && !quiet && $urandom_range(0, 15) == 0)
                burst = $urandom_range(1, 12);
            out_stall <= (burst > 0) || (hold > 0);
            if (burst > 0) burst--;
            if (hold > 0) hold--;
        end
    end

    function automatic int unsigned idle_gap();
        if (quiet || $urandom_range(0, 9) != 0) return 0;
        return $urandom_range(1, 12);
    endfunction

    function automatic t_in_beat fixed_reading(bit [TIME_W-1:0] ts, bit [VOLT_W-1:0] volt,
                                               logic [CUR_W-1:0] cur, bit [POW_W-1:0] pow);
        t_in_beat b;
        b.timestamp_ms     = ts;
        b.bus_voltage_mv   = volt;
        b.current_tenth_ma = cur;
        b.power_tenth_mw   = pow;
        return b;
    endfunction

    function automatic t_in_beat make_reading(bit [TIME_W-1:0] ts);
        t_in_beat b;
        b.timestamp_ms     = ts;
        b.bus_voltage_mv   = VOLT_W'($urandom);
        b.current_tenth_ma = CUR_W'($urandom);
        b.power_tenth_mw   = POW_W'($urandom);
        if ($urandom_range(0, 7) == 0)
            b.bus_voltage_mv = $urandom_range(0, 1) ? VOLT_MAX_VAL : '0;
        if ($urandom_range(0, 7) == 0)
            b.current_tenth_ma = $urandom_range(0, 1) ? CUR_MAX_VAL : CUR_MIN_VAL;
        if ($urandom_range(0, 7) == 0)
            b.power_tenth_mw = $urandom_range(0, 1) ? POW_MAX_VAL : '0;
        return b;
    endfunction

    // mostly valid steps past the sample period, some early, backward or huge
    function automatic bit [TIME_W-1:0] next_stamp();
        bit [TIME_W-1:0] prev;
        bit [TIME_W-1:0] sp;
        bit [TIME_W-1:0] span;
        int unsigned     pick;
        prev = tracker.prev_time;
        sp   = 32'(tracker.sample_period);
        span = (sp < 400) ? 32'd400 : sp;
        pick = $urandom_range(0, 99);
        if (pick < 8 && sp > 0) return prev + $urandom_range(0, sp - 1);
        if (pick < 14) return prev + HALF_TURN + $urandom_range(0, HALF_TURN - 1);
        if (pick < 20) return prev + sp;
        if (pick < 28) return prev + $urandom_range(0, HALF_TURN - 1);
        return prev + sp + $urandom_range(0, span);
    endfunction

    task automatic send_beat(input t_in_beat b, input int unsigned gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (in_stall);
        tracker.note_reading(b);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
    endtask

    task automatic program_regs(input bit [SPER_W-1:0] sp, input bit [TIME_W-1:0] lp,
                                input bit [TIME_W-1:0] smp);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_DAT_W-1:0] val [4];
        wait_results();
        idx = '{CFG_UNUSED, CFG_SAMPLE_PERIOD, CFG_LIVE_PERIOD, CFG_SUMMARY_PERIOD};
        val = '{$urandom, {16'($urandom), sp}, lp, smp};
        for (int k = 0; k < 4; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge clk); while (!cfg_ready);
            tracker.write_reg(idx[k], val[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_samples(input int count);
        int goal;
        goal = tracker.samples + count;
        while (tracker.samples < goal) send_beat(make_reading(next_stamp()), idle_gap());
    endtask

    initial begin : stimulus
        bit [TIME_W-1:0] t0;
        bit [SPER_W-1:0] sp;
        bit [TIME_W-1:0] lp;
        bit [TIME_W-1:0] smp;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset periods: start, early, extremes, backward, half turn, wrap
        t0 = 32'hFFFF_FE00;
        send_beat(fixed_reading(t0, '0, CUR_MIN_VAL, '0), 0);
        send_beat(fixed_reading(t0 + 50, VOLT_MAX_VAL, CUR_MAX_VAL, POW_MAX_VAL), 0);
        send_beat(fixed_reading(t0 + 100, VOLT_MAX_VAL, CUR_MAX_VAL, POW_MAX_VAL), 0);
        send_beat(make_reading(t0 + 95), 0);
        send_beat(make_reading(t0 + 100 + HALF_TURN), 0);
        send_beat(fixed_reading(t0 + 1100, '0, CUR_MIN_VAL, '0), 0);
        send_beat(fixed_reading(t0 + 1100 + HALF_TURN - 1, VOLT_MAX_VAL, CUR_MIN_VAL,
                                POW_MAX_VAL), 0);
        send_beat(make_reading(tracker.prev_time + 60000), 0);

        // zero sample and live periods, then walk the clock round to the start for zero elapsed
        program_regs(16'd0, 32'd0, 32'd1);
        send_beat(make_reading(tracker.prev_time), 0);
        send_beat(make_reading(tracker.prev_time + 1), 0);
        send_beat(make_reading(tracker.prev_time + QUARTER_TURN), 0);
        while (t0 - tracker.prev_time >= HALF_TURN)
            send_beat(make_reading(tracker.prev_time + QUARTER_TURN), 0);
        send_beat(make_reading(t0), 0);
        send_beat(fixed_reading(t0 + 1, VOLT_MAX_VAL, CUR_MAX_VAL, POW_MAX_VAL), 0);

        sp  = 16'($urandom_range(1, 300));
        lp  = $urandom_range(sp, 5000);
        smp = $urandom_range(lp, 8 * lp);
        program_regs(sp, lp, smp);
        run_samples(PHASE_SAMPLES / 2);
        long_hold = 300;
        run_samples(PHASE_SAMPLES / 2);

        program_regs('1, '1, '1);
        run_samples(PHASE_SAMPLES);

        program_regs(16'd1, 32'd1, 32'd1);
        run_samples(PHASE_SAMPLES / 2);
        wait_results();
        run_samples(PHASE_SAMPLES / 2);

        program_regs(16'd0, 32'd0, 32'd0);
        run_samples(PHASE_SAMPLES);

        program_regs(16'($urandom), $urandom, $urandom);
        run_samples(PHASE_SAMPLES);

        // tail with both sides flowing freely
        quiet = 1'b1;
        program_regs(16'd50, 32'd400, 32'd2000);
        run_samples(200);

        wait_results();
        repeat (SETTLE) @(posedge clk);

        $display("ran %0d readings, %0d taken as samples, %0d live and %0d summary deadlines",
                 tracker.beats, tracker.samples, tracker.lives, tracker.summaries);
        $display("checked %0d results over eight period settings, %0d field errors",
                 tracker.checked, tracker.errors);
        if (tracker.errors == 0) begin
            $display("power_energy_accumulator_unit: match");
        end else begin
            $display("power_energy_accumulator_unit: mismatch");
        end
        $finish;
    end

endmodule
